/* rtl/lr_pkg.sv */
package lr_pkg;

  // Default coordinate width: columns and rows run from 0 to 2**COORD_BITS - 1.
  localparam int unsigned COORD_BITS_DEF = 12;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_COLUMN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_ROW    = 1'b1;

  // Input transaction modes.
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_STEP  = 1'b1;

endpackage

/* rtl/lr_if.sv */
// Command channel: start a line or step to its next dot.
interface lr_in_if #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS:0]   x_start;
  logic signed [COORD_BITS:0]   y_start;
  logic signed [COORD_BITS:0]   x_end;
  logic signed [COORD_BITS:0]   y_end;
  logic                         color;

  modport source (
    output valid, mode, x_start, y_start, x_end, y_end, color,
    input  ready
  );
  modport sink (
    input  valid, mode, x_start, y_start, x_end, y_end, color,
    output ready
  );
endinterface

// Dot channel: one transaction per rasterised pixel.
interface lr_out_if #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [COORD_BITS-1:0]   dot_x;
  logic [COORD_BITS-1:0]   dot_y;
  logic                    dot_color;
  logic                    last_dot;

  modport source (
    output valid, dot_x, dot_y, dot_color, last_dot,
    input  ready
  );
  modport sink (
    input  valid, dot_x, dot_y, dot_color, last_dot,
    output ready
  );
endinterface

/* rtl/lr_engine.sv */
module lr_engine #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        mode_i,
  input  logic signed [COORD_BITS:0]  x_start_i,
  input  logic signed [COORD_BITS:0]  y_start_i,
  input  logic signed [COORD_BITS:0]  x_end_i,
  input  logic signed [COORD_BITS:0]  y_end_i,
  input  logic                        color_i,
  input  logic [COORD_BITS-1:0]       last_column_i,
  input  logic [COORD_BITS-1:0]       last_row_i,
  output logic                        emit_o,
  output logic [COORD_BITS-1:0]       dot_x_o,
  output logic [COORD_BITS-1:0]       dot_y_o,
  output logic                        dot_color_o,
  output logic                        last_dot_o
);

  localparam int unsigned CB = COORD_BITS;

  // Line state.
  logic          active_q, active_d;
  logic [CB-1:0] origin_x_q, origin_x_d;
  logic [CB-1:0] origin_y_q, origin_y_d;
  logic [CB-1:0] major_q, major_d;
  logic [CB-1:0] minor_q, minor_d;
  logic [CB-1:0] step_q, step_d;
  logic [CB-1:0] offset_q, offset_d;
  logic [CB:0]   rem_q, rem_d;
  logic          x_major_q, x_major_d;
  logic          x_falls_q, x_falls_d;
  logic          y_falls_q, y_falls_d;
  logic          color_q, color_d;

  // Start decode signals.
  logic          in_range;
  logic          swap;
  logic [CB-1:0] sx, sy, ex, ey;
  logic          new_x_falls, new_y_falls, new_x_major;
  logic [CB-1:0] len_x, len_y;

  // Step signals.
  logic          is_last;
  logic [CB-1:0] ceil_off;
  logic [CB:0]   rem_sum;
  logic          rem_wrap;

  // Endpoint range check: no sign bit set and no coordinate past the limits.
  assign in_range = !(x_start_i[CB] || y_start_i[CB] || x_end_i[CB] || y_end_i[CB]) &&
                    (x_start_i[CB-1:0] <= last_column_i) &&
                    (x_end_i[CB-1:0]   <= last_column_i) &&
                    (y_start_i[CB-1:0] <= last_row_i) &&
                    (y_end_i[CB-1:0]   <= last_row_i);

  // Once in range all coordinates are non-negative, so unsigned compares suffice.
  always_comb begin
    swap        = (x_start_i[CB-1:0] > x_end_i[CB-1:0]) &&
                  (y_start_i[CB-1:0] > y_end_i[CB-1:0]);
    sx          = swap ? x_end_i[CB-1:0]   : x_start_i[CB-1:0];
    ex          = swap ? x_start_i[CB-1:0] : x_end_i[CB-1:0];
    sy          = swap ? y_end_i[CB-1:0]   : y_start_i[CB-1:0];
    ey          = swap ? y_start_i[CB-1:0] : y_end_i[CB-1:0];
    new_x_falls = sx > ex;
    new_y_falls = sy > ey;
    len_x       = new_x_falls ? (sx - ex) : (ex - sx);
    len_y       = new_y_falls ? (sy - ey) : (ey - sy);
    new_x_major = len_x > len_y;
  end

  // Current dot from the accumulated quotient and remainder.
  always_comb begin
    is_last  = step_q >= major_q;
    ceil_off = offset_q + {{(CB-1){1'b0}}, (rem_q != '0)};
    if (x_major_q) begin
      dot_x_o = x_falls_q ? (origin_x_q - step_q) : (origin_x_q + step_q);
      dot_y_o = y_falls_q ? (origin_y_q - ceil_off) : (origin_y_q + offset_q);
    end else begin
      dot_y_o = y_falls_q ? (origin_y_q - step_q) : (origin_y_q + step_q);
      dot_x_o = x_falls_q ? (origin_x_q - ceil_off) : (origin_x_q + offset_q);
    end
    dot_color_o = color_q;
    last_dot_o  = is_last;
  end

  assign emit_o = accept_i && (mode_i == lr_pkg::MODE_STEP) && active_q;

  // Remainder update: the minor length never exceeds the major, so one subtract.
  assign rem_sum  = rem_q + {1'b0, minor_q};
  assign rem_wrap = rem_sum >= {1'b0, major_q};

  // Next-state selection.
  always_comb begin
    active_d   = active_q;
    origin_x_d = origin_x_q;
    origin_y_d = origin_y_q;
    major_d    = major_q;
    minor_d    = minor_q;
    step_d     = step_q;
    offset_d   = offset_q;
    rem_d      = rem_q;
    x_major_d  = x_major_q;
    x_falls_d  = x_falls_q;
    y_falls_d  = y_falls_q;
    color_d    = color_q;
    if (accept_i && (mode_i == lr_pkg::MODE_START)) begin
      active_d = in_range;
      if (in_range) begin
        origin_x_d = sx;
        origin_y_d = sy;
        major_d    = new_x_major ? len_x : len_y;
        minor_d    = new_x_major ? len_y : len_x;
        step_d     = '0;
        offset_d   = '0;
        rem_d      = '0;
        x_major_d  = new_x_major;
        x_falls_d  = new_x_falls;
        y_falls_d  = new_y_falls;
        color_d    = color_i;
      end
    end else if (emit_o) begin
      if (is_last) begin
        active_d = 1'b0;
      end else begin
        step_d = step_q + 1'b1;
        if (rem_wrap) begin
          rem_d    = rem_sum - {1'b0, major_q};
          offset_d = offset_q + 1'b1;
        end else begin
          rem_d = rem_sum;
        end
      end
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= 1'b0;
      origin_x_q <= '0;
      origin_y_q <= '0;
      major_q    <= '0;
      minor_q    <= '0;
      step_q     <= '0;
      offset_q   <= '0;
      rem_q      <= '0;
      x_major_q  <= 1'b0;
      x_falls_q  <= 1'b0;
      y_falls_q  <= 1'b0;
      color_q    <= 1'b0;
    end else begin
      active_q   <= active_d;
      origin_x_q <= origin_x_d;
      origin_y_q <= origin_y_d;
      major_q    <= major_d;
      minor_q    <= minor_d;
      step_q     <= step_d;
      offset_q   <= offset_d;
      rem_q      <= rem_d;
      x_major_q  <= x_major_d;
      x_falls_q  <= x_falls_d;
      y_falls_q  <= y_falls_d;
      color_q    <= color_d;
    end
  end

endmodule

/* rtl/line_rasterizer.sv */
// A step transaction's dot is held in the output register before it reaches the output
// channel; start transactions produce no dot.
// Throughput: one input transaction per cycle; the output register is the only
// stage, so input stalls only while a dot is held and the sink is not ready.
// Reset (asynchronous, active low) clears the limits, ends any line and
// empties the output register.
module line_rasterizer #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lr_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [COORD_BITS-1:0]          cfg_wdata_i,
  lr_in_if.sink                          in_i,
  lr_out_if.source                       out_o
);

  logic [COORD_BITS-1:0] last_column_q;
  logic [COORD_BITS-1:0] last_row_q;
  logic                  accept;
  logic                  emit;
  logic [COORD_BITS-1:0] dot_x, dot_y;
  logic                  dot_color, last_dot;
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] dot_x_q, dot_y_q;
  logic                  dot_color_q, last_dot_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_column_q <= '0;
      last_row_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lr_pkg::REG_LAST_COLUMN: last_column_q <= cfg_wdata_i;
        lr_pkg::REG_LAST_ROW:    last_row_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Input is taken whenever the output register is free or being emptied.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  lr_engine #(
    .COORD_BITS (COORD_BITS)
  ) u_lr_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .mode_i        (in_i.mode),
    .x_start_i     (in_i.x_start),
    .y_start_i     (in_i.y_start),
    .x_end_i       (in_i.x_end),
    .y_end_i       (in_i.y_end),
    .color_i       (in_i.color),
    .last_column_i (last_column_q),
    .last_row_i    (last_row_q),
    .emit_o        (emit),
    .dot_x_o       (dot_x),
    .dot_y_o       (dot_y),
    .dot_color_o   (dot_color),
    .last_dot_o    (last_dot)
  );

  // Output register.
  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      dot_x_q     <= dot_x;
      dot_y_q     <= dot_y;
      dot_color_q <= dot_color;
      last_dot_q  <= last_dot;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.dot_x     = dot_x_q;
  assign out_o.dot_y     = dot_y_q;
  assign out_o.dot_color = dot_color_q;
  assign out_o.last_dot  = last_dot_q;

endmodule

/* rtl/lr_checker.sv */
module lr_checker #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_mode_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [COORD_BITS-1:0] dot_x_i,
  input logic [COORD_BITS-1:0] dot_y_i,
  input logic                  dot_color_i,
  input logic                  last_dot_i
);

  // A held dot keeps its payload until its transaction completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dot_x_i) && $stable(dot_y_i) &&
      $stable(dot_color_i) && $stable(last_dot_i))
    else $error("lr_checker: held dot changed before its transaction");

  // The block never stalls the input while its output register is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("lr_checker: input stalled with an empty output register");

  // A start transaction never produces a dot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_mode_i == lr_pkg::MODE_START) &&
      (!out_valid_i || out_ready_i) |=> !out_valid_i)
    else $error("lr_checker: dot produced by a start transaction");

  // A new dot appears only after an accepted step transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && (in_mode_i == lr_pkg::MODE_STEP)))
    else $error("lr_checker: dot appeared without a step transaction");

endmodule

bind line_rasterizer lr_checker #(
  .COORD_BITS (COORD_BITS)
) u_lr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_mode_i   (in_i.mode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .dot_x_i     (out_o.dot_x),
  .dot_y_i     (out_o.dot_y),
  .dot_color_i (out_o.dot_color),
  .last_dot_i  (out_o.last_dot)
);
